### rtl/rbrt_pkg.sv
// Shared types, codes and constants of the removed-bucket replacement table.
package rbrt_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int DEF_ID_BITS  = 16;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 18;
    localparam int COUNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_REMEMBER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTORE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    localparam logic [VALUE_W-1:0] VALUE_NEG1 = '1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_COMMIT
    } rbrt_state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic scan;
        logic commit;
    } rbrt_ctrl_t;

    typedef struct packed {
        logic idx_last;
        logic skip_scan;
        logic out_free;
    } rbrt_stat_t;

endpackage

### rtl/rbrt_cmd_if.sv
// Command channel interface of the removed-bucket replacement table.
interface rbrt_cmd_if
    import rbrt_pkg::*;
#(
    parameter int ID_BITS = DEF_ID_BITS
);
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [ID_BITS-1:0] bucket_id;
    logic [ID_BITS-1:0] replacer_id;
    logic [ID_BITS-1:0] prior_removed;

    modport source (
        output valid, command, bucket_id, replacer_id, prior_removed,
        input  ready
    );

    modport sink (
        input  valid, command, bucket_id, replacer_id, prior_removed,
        output ready
    );
endinterface

### rtl/rbrt_rsp_if.sv
// Result channel interface of the removed-bucket replacement table.
interface rbrt_rsp_if
    import rbrt_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]         entry_count;

    modport source (
        output valid, status, value, entry_count,
        input  ready
    );

    modport sink (
        input  valid, status, value, entry_count,
        output ready
    );
endinterface

### rtl/removed_bucket_replacement_table_unit.sv
// A remember, query or non-empty restore runs a linear scan of the entry memory at one
// read per cycle between its transfer in and its result. Commands are taken one at a time;
// a restore on an empty table or an unused command code skips the scan. A finished result
// may wait while the next is taken.
// Reset: asynchronous, active low; afterwards a clearing pass over every entry
// invalidates it, and no command is taken until it ends.
module removed_bucket_replacement_table_unit
    import rbrt_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int ID_BITS  = DEF_ID_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    rbrt_cmd_if.sink      cmd,
    rbrt_rsp_if.source    rsp
);

    // The controller sequences each command through load, scan, a drain of the
    // read pipeline and commit; a command with no scan skips both. The datapath
    // owns the entry memory, match and free-slot trackers, and result register.
    rbrt_ctrl_t ctl;
    rbrt_stat_t stat;

    rbrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // The result register decouples the two sides: a result that waits
    // for its transfer out does not hold back the next command.
    rbrt_dp #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .stat             (stat),
        .in_command       (cmd.command),
        .in_bucket_id     (cmd.bucket_id),
        .in_replacer_id   (cmd.replacer_id),
        .in_prior_removed (cmd.prior_removed),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .out_status       (rsp.status),
        .out_value        (rsp.value),
        .out_entry_count  (rsp.entry_count)
    );

endmodule

### rtl/rbrt_ctrl.sv
// Controller state machine: clearing pass, table scan, commit and handoff.
module rbrt_ctrl
    import rbrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  rbrt_stat_t stat,
    output rbrt_ctrl_t ctl
);

    rbrt_state_t state_reg;
    rbrt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clear = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.skip_scan)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    ctl.scan = 1'b1;
                    if (stat.idx_last)
                    begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                // The last read entry is checked in this cycle.
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

### rtl/rbrt_dp.sv
// Datapath: entry memory, scan trackers, entry count and result register.
module rbrt_dp
    import rbrt_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int ID_BITS  = DEF_ID_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  rbrt_ctrl_t                ctl,
    output rbrt_stat_t                stat,
    input  logic [CMD_W-1:0]          in_command,
    input  logic [ID_BITS-1:0]        in_bucket_id,
    input  logic [ID_BITS-1:0]        in_replacer_id,
    input  logic [ID_BITS-1:0]        in_prior_removed,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [STATUS_W-1:0]       out_status,
    output logic signed [VALUE_W-1:0] out_value,
    output logic [COUNT_W-1:0]        out_entry_count
);

    localparam int AW      = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ENTRY_W = 3 * ID_BITS + 1;
    localparam int EXT_W   = ID_BITS + VALUE_W;
    localparam int CEXT_W  = CNT_W + COUNT_W;

    // Entry word: valid flag, key, replacer, prior removed.
    logic [ENTRY_W-1:0] mem [CAPACITY];

    logic [AW-1:0]      idx_reg;
    logic [CMD_W-1:0]   item_cmd_reg;
    logic [ID_BITS-1:0] key_reg;
    logic [ID_BITS-1:0] rep_reg;
    logic [ID_BITS-1:0] prior_reg;

    logic               chk_vld_reg;
    logic [AW-1:0]      chk_idx_reg;
    logic [ENTRY_W-1:0] rd_data_reg;

    logic               hit_found_reg;
    logic [AW-1:0]      hit_slot_reg;
    logic [ID_BITS-1:0] hit_rep_reg;
    logic [ID_BITS-1:0] hit_prior_reg;
    logic               free_found_reg;
    logic [AW-1:0]      free_slot_reg;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [COUNT_W-1:0]  entry_count_reg;

    logic                rd_valid;
    logic [ID_BITS-1:0]  rd_key;
    logic                rd_match;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic [STATUS_W-1:0] status_next;
    logic [VALUE_W-1:0]  value_next;
    logic [EXT_W-1:0]    key_ext;
    logic [EXT_W-1:0]    key_inc_ext;
    logic [EXT_W-1:0]    rep_ext;
    logic [EXT_W-1:0]    prior_ext;
    logic [CEXT_W-1:0]   count_ext;

    assign rd_valid = rd_data_reg[ENTRY_W-1];
    assign rd_key   = rd_data_reg[3*ID_BITS-1:2*ID_BITS];
    assign rd_match = rd_valid && (rd_key == key_reg);

    assign key_ext     = EXT_W'(key_reg);
    assign key_inc_ext = EXT_W'(key_reg) + EXT_W'(1);
    assign rep_ext     = EXT_W'(hit_rep_reg);
    assign prior_ext   = EXT_W'(hit_prior_reg);
    assign count_ext   = CEXT_W'(count_next);

    assign stat.idx_last  = (idx_reg == AW'(CAPACITY - 1));
    assign stat.skip_scan = !((item_cmd_reg == CMD_REMEMBER) || (item_cmd_reg == CMD_QUERY)
                              || ((item_cmd_reg == CMD_RESTORE) && (count_reg != '0)));
    assign stat.out_free  = !out_valid_reg || out_ready;

    // Clearing write and commit decision: memory write, count update and the result.
    always_comb
    begin
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = '0;
        count_next  = count_reg;
        status_next = ST_MISSING;
        value_next  = VALUE_NEG1;
        if (ctl.clear)
        begin
            wr_en = 1'b1;
        end
        else if (ctl.commit)
        begin
            case (item_cmd_reg)
                CMD_REMEMBER:
                begin
                    wr_data = {1'b1, key_reg, rep_reg, prior_reg};
                    if (hit_found_reg)
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = hit_slot_reg;
                        status_next = ST_OK;
                        value_next  = key_ext[VALUE_W-1:0];
                    end
                    else if (free_found_reg)
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = free_slot_reg;
                        count_next  = count_reg + CNT_W'(1);
                        status_next = ST_OK;
                        value_next  = key_ext[VALUE_W-1:0];
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                CMD_QUERY:
                begin
                    if (hit_found_reg)
                    begin
                        status_next = ST_OK;
                        value_next  = rep_ext[VALUE_W-1:0];
                    end
                end
                CMD_RESTORE:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_OK;
                        value_next  = key_inc_ext[VALUE_W-1:0];
                    end
                    else if (hit_found_reg)
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = hit_slot_reg;
                        count_next  = count_reg - CNT_W'(1);
                        status_next = ST_OK;
                        value_next  = prior_ext[VALUE_W-1:0];
                    end
                end
                default:
                begin
                    status_next = ST_MISSING;
                end
            endcase
        end
    end

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Memory read port, one entry per scan cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.scan)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            chk_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            chk_vld_reg <= ctl.scan;
            if (ctl.load)
            begin
                idx_reg <= '0;
            end
            else if (ctl.clear || ctl.scan)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (ctl.load)
            begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (chk_vld_reg)
            begin
                if (rd_match)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (!rd_valid)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            count_reg <= count_next;
            if (ctl.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        chk_idx_reg <= idx_reg;
        if (ctl.load)
        begin
            item_cmd_reg <= in_command;
            key_reg      <= in_bucket_id;
            rep_reg      <= in_replacer_id;
            prior_reg    <= in_prior_removed;
        end
        // Only the first match and the lowest free slot are kept.
        if (chk_vld_reg && rd_match && !hit_found_reg)
        begin
            hit_slot_reg  <= chk_idx_reg;
            hit_rep_reg   <= rd_data_reg[2*ID_BITS-1:ID_BITS];
            hit_prior_reg <= rd_data_reg[ID_BITS-1:0];
        end
        if (chk_vld_reg && !rd_valid && !free_found_reg)
        begin
            free_slot_reg <= chk_idx_reg;
        end
        if (ctl.commit)
        begin
            status_reg      <= status_next;
            value_reg       <= value_next;
            entry_count_reg <= count_ext[COUNT_W-1:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = status_reg;
    assign out_value       = value_reg;
    assign out_entry_count = entry_count_reg;

endmodule

### rtl/rbrt_checker.sv
// Port-level assertions for the removed-bucket replacement table.
module rbrt_checker
    import rbrt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] out_status,
    input logic [VALUE_W-1:0]  out_value,
    input logic [COUNT_W-1:0]  out_entry_count
);

    // A waiting result stays offered until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before its transfer");

    // A waiting result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_status) && $stable(out_value)
            && $stable(out_entry_count))
        else $error("result payload changed while stalled");

    // A missing key or a dropped insert always reports minus one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == ST_MISSING || out_status == ST_FULL)
            |-> out_value == VALUE_NEG1)
        else $error("failed command without minus one");

    // Commands are worked one at a time: no transfer in the cycle after one.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command taken while another is in work");

endmodule

bind removed_bucket_replacement_table_unit rbrt_checker u_rbrt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (cmd.valid),
    .in_ready        (cmd.ready),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_status      (rsp.status),
    .out_value       (rsp.value),
    .out_entry_count (rsp.entry_count)
);

### sim/tb_top.sv
// Self-checking testbench for the removed-bucket replacement table unit.
`timescale 1ns / 1ps

module tb_top;
    import rbrt_pkg::*;

    localparam int CAPACITY = DEF_CAPACITY;
    localparam int ID_BITS  = DEF_ID_BITS;

    // The command field is two bits wide, and the code left over after the
    // three real commands must be answered as "not found" without touching
    // the table.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Total number of commands that the run aims for, and how many of them
    // are kept for the closing stretch without any idling.
    localparam int ITEM_TARGET = 1650;
    localparam int TAIL_ITEMS  = 100;

    // One expected result, at the widths of the result channel.
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
    } table_rsp_t;

    logic clk;
    logic rst_n;

    rbrt_cmd_if #(.ID_BITS(ID_BITS)) cmd_if ();
    rbrt_rsp_if                      rsp_if ();

    removed_bucket_replacement_table_unit #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    // Free-running clock with a 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Shadow copy of the table. A slot only counts while its used bit is
    // set, which mirrors the valid bits of the block. Slot placement does
    // not show up in any result, but keeping the same lowest-free-slot rule
    // makes the full and not-full boundary line up exactly.
    logic [ID_BITS-1:0] slot_key      [CAPACITY];
    logic [ID_BITS-1:0] slot_replacer [CAPACITY];
    logic [ID_BITS-1:0] slot_prior    [CAPACITY];
    bit                 slot_used     [CAPACITY];
    int                 entries_held;

    // Results that the block still owes us, oldest first.
    table_rsp_t expected_rsp_q [$];

    int error_count;
    int items_sent;
    bit idling_on;
    int rsp_hold_cycles;

    // Every mismatch or protocol problem goes through here so that the
    // final verdict only has to look at one counter.
    task automatic report_error(input string msg);
        error_count++;
        $display("%0t ns: ERROR: %s", $time, msg);
    endtask

    // Index of the used slot that holds the key, or -1 when it is absent.
    function automatic int find_entry(input logic [ID_BITS-1:0] key);
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (slot_used[i] && slot_key[i] == key)
                return i;
        end
        return -1;
    endfunction

    // Applies one accepted command to the shadow table and returns the
    // result that the block must produce for it.
    function automatic table_rsp_t predict_table(
        input logic [CMD_W-1:0]   op,
        input logic [ID_BITS-1:0] bucket,
        input logic [ID_BITS-1:0] rep,
        input logic [ID_BITS-1:0] prior
    );
        table_rsp_t r;
        int         slot;

        r.status = ST_MISSING;
        r.value  = VALUE_NEG1;
        case (op)
            CMD_REMEMBER:
            begin
                // A key that is already stored is updated in place; a new
                // key takes the lowest free slot if there is one.
                slot = find_entry(bucket);
                if (slot < 0)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (!slot_used[i])
                        begin
                            slot = i;
                            break;
                        end
                    end
                    if (slot >= 0)
                    begin
                        slot_used[slot] = 1'b1;
                        slot_key[slot]  = bucket;
                        entries_held++;
                    end
                end
                if (slot >= 0)
                begin
                    slot_replacer[slot] = rep;
                    slot_prior[slot]    = prior;
                    r.status = ST_OK;
                    r.value  = VALUE_W'(bucket);
                end
                else
                begin
                    r.status = ST_FULL;
                    r.value  = VALUE_NEG1;
                end
            end
            CMD_QUERY:
            begin
                slot = find_entry(bucket);
                if (slot >= 0)
                begin
                    r.status = ST_OK;
                    r.value  = VALUE_W'(slot_replacer[slot]);
                end
            end
            CMD_RESTORE:
            begin
                // On an empty table the answer is the bucket plus one, which
                // for the top bucket id needs the 17th bit of the value.
                if (entries_held == 0)
                begin
                    r.status = ST_OK;
                    r.value  = VALUE_W'(bucket) + 1'b1;
                end
                else
                begin
                    slot = find_entry(bucket);
                    if (slot >= 0)
                    begin
                        slot_used[slot] = 1'b0;
                        entries_held--;
                        r.status = ST_OK;
                        r.value  = VALUE_W'(slot_prior[slot]);
                    end
                end
            end
            default:
            begin
                // The unused code leaves the table as it is.
            end
        endcase
        r.count = COUNT_W'(entries_held);
        return r;
    endfunction

    function automatic logic [ID_BITS-1:0] any_id();
        return ID_BITS'($urandom_range(0, (1 << ID_BITS) - 1));
    endfunction

    // Offers one command and waits for its transfer. When idling is on, a
    // random gap with valid low may come first. Every call starts at a
    // rising edge, and valid is assigned at most once in any time step.
    task automatic send_command(
        input logic [CMD_W-1:0]   op,
        input logic [ID_BITS-1:0] bucket,
        input logic [ID_BITS-1:0] rep,
        input logic [ID_BITS-1:0] prior
    );
        int gap;

        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.command       <= op;
        cmd_if.bucket_id     <= bucket;
        cmd_if.replacer_id   <= rep;
        cmd_if.prior_removed <= prior;
        cmd_if.valid         <= 1'b1;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        // The transfer happened at this edge, so the command is now part of
        // the block's history and its result can be predicted.
        expected_rsp_q.push_back(predict_table(op, bucket, rep, prior));
        items_sent++;
    endtask

    // Drops valid right at the last transfer and holds off until the block
    // has answered everything that was sent.
    task automatic pause_until_drained();
        cmd_if.valid <= 1'b0;
        wait (expected_rsp_q.size() == 0);
        @(posedge clk);
    endtask

    // Picks a key that is stored right now; only called with entries held.
    function automatic logic [ID_BITS-1:0] stored_key();
        int idx;

        idx = $urandom_range(0, CAPACITY - 1);
        while (!slot_used[idx])
            idx = (idx + 1) % CAPACITY;
        return slot_key[idx];
    endfunction

    // Picks a key that is not stored right now.
    function automatic logic [ID_BITS-1:0] absent_key();
        logic [ID_BITS-1:0] key;

        key = any_id();
        while (find_entry(key) >= 0)
            key = any_id();
        return key;
    endfunction

    // Field extremes, every command, and the corner cases: restore on an
    // empty table (including the top bucket id, whose answer needs the
    // 17th value bit), lookups of absent keys, an in-place update of a key
    // already present, and the unused command code on an empty and on a
    // non-empty table.
    task automatic test_directed();
        send_command(CMD_RESTORE,  16'h0000, any_id(), any_id());
        send_command(CMD_RESTORE,  16'hFFFF, any_id(), any_id());
        send_command(CMD_QUERY,    16'h0000, any_id(), any_id());
        send_command(CMD_UNUSED,   16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_command(CMD_REMEMBER, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_command(CMD_REMEMBER, 16'h0000, 16'h0000, 16'h0000);
        send_command(CMD_REMEMBER, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_command(CMD_REMEMBER, 16'h5555, 16'hAAAA, 16'h5555);
        send_command(CMD_QUERY,    16'hFFFF, any_id(), any_id());
        send_command(CMD_QUERY,    16'h0000, any_id(), any_id());
        send_command(CMD_QUERY,    16'hAAAA, any_id(), any_id());
        send_command(CMD_QUERY,    16'h5555, any_id(), any_id());
        send_command(CMD_REMEMBER, 16'hFFFF, 16'h1234, 16'h8001);
        send_command(CMD_QUERY,    16'hFFFF, any_id(), any_id());
        send_command(CMD_UNUSED,   16'hAAAA, any_id(), any_id());
        send_command(CMD_RESTORE,  16'h1357, any_id(), any_id());
        send_command(CMD_QUERY,    16'h1357, any_id(), any_id());
        send_command(CMD_RESTORE,  16'hFFFF, any_id(), any_id());
        send_command(CMD_RESTORE,  16'hFFFF, any_id(), any_id());
        send_command(CMD_RESTORE,  16'h0000, any_id(), any_id());
        send_command(CMD_RESTORE,  16'hAAAA, any_id(), any_id());
        send_command(CMD_RESTORE,  16'h5555, any_id(), any_id());
        // The table is empty again, so this restore of an absent key must
        // still answer with the bucket plus one.
        send_command(CMD_RESTORE,  16'h5555, any_id(), any_id());
        send_command(CMD_QUERY,    16'h5555, any_id(), any_id());
    endtask

    // Fills every slot with distinct keys, pushes past the capacity, checks
    // that an update still works on a full table and that a freed slot is
    // taken again, then drains the table one restore at a time.
    task automatic test_fill_and_overflow();
        logic [ID_BITS-1:0] key;

        for (int i = 0; i < CAPACITY; i++)
            send_command(CMD_REMEMBER, absent_key(), any_id(), any_id());
        repeat (3)
            send_command(CMD_REMEMBER, absent_key(), any_id(), any_id());
        send_command(CMD_REMEMBER, stored_key(), any_id(), any_id());
        repeat (4)
            send_command(CMD_QUERY, stored_key(), any_id(), any_id());
        send_command(CMD_QUERY, absent_key(), any_id(), any_id());

        send_command(CMD_RESTORE, stored_key(), any_id(), any_id());
        send_command(CMD_REMEMBER, absent_key(), any_id(), any_id());
        send_command(CMD_REMEMBER, absent_key(), any_id(), any_id());

        while (entries_held > 0)
        begin
            key = stored_key();
            send_command(CMD_RESTORE, key, any_id(), any_id());
            if ($urandom_range(0, 3) == 0)
                send_command(CMD_QUERY, key, any_id(), any_id());
            if (entries_held > 0 && $urandom_range(0, 5) == 0)
                send_command(CMD_RESTORE, absent_key(), any_id(), any_id());
        end
        send_command(CMD_RESTORE, any_id(), any_id(), any_id());
    endtask

    // One stretch of commands over a small pool of keys, so that queries
    // and restores mostly hit entries that exist. The pool size and the
    // share of remembers change from call to call: small pools with many
    // restores keep running the table dry, large pools with many remembers
    // push it into the full state. A few commands are noise: the unused
    // code or a command on a key taken from the whole id range.
    task automatic run_episode(input int len);
        logic [ID_BITS-1:0] pool [90];
        logic [CMD_W-1:0]   op;
        logic [ID_BITS-1:0] key;
        int                 pool_n;
        int                 remember_pct;
        int                 pick;

        pool_n       = $urandom_range(2, 90);
        remember_pct = $urandom_range(20, 70);
        for (int i = 0; i < pool_n; i++)
            pool[i] = any_id();
        repeat (len)
        begin
            pick = $urandom_range(0, 99);
            key  = pool[$urandom_range(0, pool_n - 1)];
            if (pick < 3)
            begin
                op  = CMD_UNUSED;
                key = any_id();
            end
            else if (pick < 8)
            begin
                case ($urandom_range(0, 2))
                    0:       op = CMD_REMEMBER;
                    1:       op = CMD_QUERY;
                    default: op = CMD_RESTORE;
                endcase
                key = any_id();
            end
            else if (pick < 8 + remember_pct)
                op = CMD_REMEMBER;
            else if (pick[0])
                op = CMD_QUERY;
            else
                op = CMD_RESTORE;
            send_command(op, key, any_id(), any_id());
        end
    endtask

    // The receiver holds off for a long stretch while commands keep coming,
    // so the block fills its pipeline and must stall the command channel.
    // Afterwards the sender waits for the block to answer everything.
    task automatic test_backpressure();
        rsp_hold_cycles = 400;
        repeat (8)
            run_episode(1);
        pause_until_drained();
    endtask

    // The bulk of the run, with random idling on both sides.
    task automatic test_random_mix(input int target);
        idling_on = 1'b1;
        while (items_sent < target)
            run_episode($urandom_range(20, 80));
    endtask

    // A closing stretch with no idling on either side.
    task automatic test_quiet_tail(input int count);
        int stop_at;

        idling_on = 1'b0;
        stop_at   = items_sent + count;
        while (items_sent < stop_at)
            run_episode(stop_at - items_sent < 40 ? stop_at - items_sent : 40);
    endtask

    // Result sampling: a transfer happens at an edge where valid and ready
    // are both high, and it is compared with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        table_rsp_t want;

        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (expected_rsp_q.size() == 0)
                report_error($sformatf("result with nothing expected: status %0d value %0d",
                                       rsp_if.status, rsp_if.value));
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp_if.status !== want.status)
                    report_error($sformatf("status: got %0d, expected %0d",
                                           rsp_if.status, want.status));
                if (rsp_if.value !== want.value)
                    report_error($sformatf("value: got %0d, expected %0d",
                                           rsp_if.value, want.value));
                if (rsp_if.entry_count !== want.count)
                    report_error($sformatf("entry_count: got %0d, expected %0d",
                                           rsp_if.entry_count, want.count));
            end
        end
    end

    // Receiver side. A requested long hold-off takes priority; otherwise,
    // while idling is on, ready drops for random bursts. Each branch
    // assigns ready once per time step.
    initial
    begin : drive_ready
        int burst;

        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_hold_cycles > 0)
            begin
                burst           = rsp_hold_cycles;
                rsp_hold_cycles = 0;
                rsp_if.ready <= 1'b0;
                repeat (burst) @(posedge clk);
                rsp_if.ready <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 13);
                rsp_if.ready <= 1'b0;
                repeat (burst) @(posedge clk);
                rsp_if.ready <= 1'b1;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // Safety net. The limit sits far above the slowest correct run, even
    // with every stall at its longest, so it only trips on a hung
    // handshake.
    initial
    begin : run_limit
        #4_000_000;
        $display("** removed_bucket_replacement_table_unit: FAILED **");
        $finish;
    end

    // Main sequence. After reset the block runs a clearing pass over all
    // slots before it takes any command; the first send simply waits for
    // ready.
    initial
    begin : main_sequence
        error_count     = 0;
        items_sent      = 0;
        idling_on       = 1'b1;
        rsp_hold_cycles = 0;
        entries_held    = 0;
        for (int i = 0; i < CAPACITY; i++)
            slot_used[i] = 1'b0;

        rst_n                <= 1'b0;
        cmd_if.valid         <= 1'b0;
        cmd_if.command       <= CMD_REMEMBER;
        cmd_if.bucket_id     <= '0;
        cmd_if.replacer_id   <= '0;
        cmd_if.prior_removed <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_overflow();
        test_backpressure();
        test_random_mix(ITEM_TARGET - TAIL_ITEMS);
        test_quiet_tail(TAIL_ITEMS);

        // Let the last results come, then give the block a full scan's
        // worth of cycles to show any result that nobody asked for.
        pause_until_drained();
        repeat (CAPACITY + 16) @(posedge clk);

        if (error_count == 0)
            $display("** removed_bucket_replacement_table_unit: PASSED **");
        else
            $display("** removed_bucket_replacement_table_unit: FAILED **");
        $finish;
    end

endmodule
